>>> sv/thtrk_pkg.sv
// shared types, constants and beat packing for the tcp handshake tracker
// no dependencies; used by every module of the block
package thtrk_pkg;

   localparam int unsigned IP_W      = 32;
   localparam int unsigned PORT_W    = 16;
   localparam int unsigned SEQ_W     = 32;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned FLAG_W    = 8;
   localparam int unsigned FAKE_W    = 11;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   // beat widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 216;
   localparam int unsigned RSP_DATA_W = 56;

   localparam logic [SEQ_W-1:0]  NOT_SEEN  = '1;
   localparam logic [LEN_W-1:0]  MIN_LEN   = 16'd20;
   localparam logic [3:0]        IPV4      = 4'd4;
   localparam logic [7:0]        PROTO_TCP = 8'd6;

   localparam logic [FLAG_W-1:0] F_FIN = 8'h01;
   localparam logic [FLAG_W-1:0] F_SYN = 8'h02;
   localparam logic [FLAG_W-1:0] F_RST = 8'h04;
   localparam logic [FLAG_W-1:0] F_PSH = 8'h08;
   localparam logic [FLAG_W-1:0] F_ACK = 8'h10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOCAL_IP     = 3'd0,
      CSR_LOCAL_PORT   = 3'd1,
      CSR_REMOTE_IP    = 3'd2,
      CSR_REMOTE_PORT  = 3'd3,
      CSR_FAKE_LEN     = 3'd4,
      CSR_TRACK_ENABLE = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      OUTCOME_NONE    = 2'd0,
      OUTCOME_SUCCESS = 2'd1,
      OUTCOME_CLOSED  = 2'd2
   } outcome_type;

   typedef enum logic [3:0] {
      RSN_NONE            = 4'd0,
      RSN_SYNACK_NO_SYN   = 4'd1,
      RSN_SYNACK_SEQ      = 4'd2,
      RSN_SYNACK_ACK      = 4'd3,
      RSN_IN_ACK_SEQ      = 4'd4,
      RSN_IN_ACK_ACK      = 4'd5,
      RSN_IN_OTHER        = 4'd6,
      RSN_AFTER_FAKE      = 4'd7,
      RSN_SYN_ACK_NONZERO = 4'd8,
      RSN_SYN_SEQ         = 4'd9,
      RSN_OUT_ACK_SEQ     = 4'd10,
      RSN_OUT_ACK_ACK     = 4'd11,
      RSN_OUT_OTHER       = 4'd12
   } reason_type;

   typedef struct packed {
      logic [LEN_W-1:0]  payload_len;
      logic [SEQ_W-1:0]  ack_num;
      logic [SEQ_W-1:0]  seq_num;
      logic [FLAG_W-1:0] tcp_flags;
      logic [PORT_W-1:0] dst_port;
      logic [PORT_W-1:0] src_port;
      logic [IP_W-1:0]   dst_ip;
      logic [IP_W-1:0]   src_ip;
      logic [7:0]        protocol;
      logic [3:0]        ip_version;
      logic [LEN_W-1:0]  packet_len;
      logic              outbound;
   } hdr_type;

   typedef struct packed {
      reason_type        reason;
      outcome_type       outcome;
      logic              matched;
      logic [FLAG_W-1:0] fake_flags;
      logic [SEQ_W-1:0]  fake_seq;
      logic              inject_fake;
      logic              forward;
   } result_type;

   typedef struct packed {
      logic [IP_W-1:0]   local_ip;
      logic [PORT_W-1:0] local_port;
      logic [IP_W-1:0]   remote_ip;
      logic [PORT_W-1:0] remote_port;
      logic [FAKE_W-1:0] fake_len;
   } conn_cfg_type;

   typedef struct packed {
      logic [SEQ_W-1:0] syn_seq;
      logic [SEQ_W-1:0] synack_seq;
      logic             monitoring;
      logic             fake_done;
      outcome_type      final_outcome;
   } track_state_type;

   // outbound sits in bit 0, remaining fields follow upwards
   function automatic hdr_type unpack_req(input logic [REQ_DATA_W-1:0] data);
      return hdr_type'(data[$bits(hdr_type)-1:0]);
   endfunction

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(input result_type res);
      return {{(RSP_DATA_W-$bits(result_type)){1'b0}}, res};
   endfunction

endpackage

>>> sv/thtrk_decide.sv
// per-beat decision logic: connection match and handshake checks
// depends on thtrk_pkg; purely combinational, sits between the tracker's registers
module thtrk_decide (
   input  thtrk_pkg::hdr_type         hdr,
   input  thtrk_pkg::conn_cfg_type    cfg,
   input  thtrk_pkg::track_state_type cur,
   output thtrk_pkg::result_type      res,
   output thtrk_pkg::track_state_type nxt
);

   logic                        is_tcp4;
   logic                        match_out;
   logic                        match_in;
   logic                        matched;
   logic                        bare;
   logic                        has_syn;
   logic                        has_ack;
   logic [thtrk_pkg::SEQ_W-1:0] syn_plus1;
   logic [thtrk_pkg::SEQ_W-1:0] synack_plus1;
   logic                        syn_seen;
   logic                        synack_seen;
   thtrk_pkg::reason_type       reason;

   assign is_tcp4 = (hdr.packet_len >= thtrk_pkg::MIN_LEN) &&
                    (hdr.ip_version == thtrk_pkg::IPV4) &&
                    (hdr.protocol == thtrk_pkg::PROTO_TCP);

   assign match_out = (hdr.src_ip == cfg.local_ip) && (hdr.src_port == cfg.local_port) &&
                      (hdr.dst_ip == cfg.remote_ip) && (hdr.dst_port == cfg.remote_port);
   assign match_in  = (hdr.dst_ip == cfg.local_ip) && (hdr.dst_port == cfg.local_port) &&
                      (hdr.src_ip == cfg.remote_ip) && (hdr.src_port == cfg.remote_port);
   assign matched   = is_tcp4 && (hdr.outbound ? match_out : match_in);

   assign bare    = ((hdr.tcp_flags & (thtrk_pkg::F_RST | thtrk_pkg::F_FIN)) == '0) &&
                    (hdr.payload_len == '0);
   assign has_syn = |(hdr.tcp_flags & thtrk_pkg::F_SYN);
   assign has_ack = |(hdr.tcp_flags & thtrk_pkg::F_ACK);

   assign syn_plus1    = cur.syn_seq + thtrk_pkg::SEQ_W'(1);
   assign synack_plus1 = cur.synack_seq + thtrk_pkg::SEQ_W'(1);
   assign syn_seen     = (cur.syn_seq != thtrk_pkg::NOT_SEEN);
   assign synack_seen  = (cur.synack_seq != thtrk_pkg::NOT_SEEN);

   always_comb begin
      nxt             = cur;
      reason          = thtrk_pkg::RSN_NONE;
      res.forward     = 1'b1;
      res.inject_fake = 1'b0;
      res.fake_seq    = '0;
      res.fake_flags  = '0;
      res.matched     = matched;

      if (matched && cur.monitoring) begin
         if (!hdr.outbound) begin
            if (has_syn && has_ack && bare) begin
               // syn-ack from the remote end
               if (!syn_seen) begin
                  reason = thtrk_pkg::RSN_SYNACK_NO_SYN;
               end else if (synack_seen && (cur.synack_seq != hdr.seq_num)) begin
                  reason = thtrk_pkg::RSN_SYNACK_SEQ;
               end else if (hdr.ack_num != syn_plus1) begin
                  reason = thtrk_pkg::RSN_SYNACK_ACK;
               end else begin
                  nxt.synack_seq = hdr.seq_num;
               end
            end else if (has_ack && !has_syn && bare && cur.fake_done) begin
               // remote acknowledges the fake data
               if (!synack_seen || (hdr.seq_num != synack_plus1)) begin
                  reason = thtrk_pkg::RSN_IN_ACK_SEQ;
               end else if (hdr.ack_num != syn_plus1) begin
                  reason = thtrk_pkg::RSN_IN_ACK_ACK;
               end else begin
                  nxt.monitoring    = 1'b0;
                  nxt.final_outcome = thtrk_pkg::OUTCOME_SUCCESS;
                  res.forward       = 1'b0;
               end
            end else begin
               reason = thtrk_pkg::RSN_IN_OTHER;
            end
         end else begin
            if (cur.fake_done) begin
               reason = thtrk_pkg::RSN_AFTER_FAKE;
            end else if (has_syn && !has_ack && bare) begin
               if (hdr.ack_num != '0) begin
                  reason = thtrk_pkg::RSN_SYN_ACK_NONZERO;
               end else if (syn_seen && (cur.syn_seq != hdr.seq_num)) begin
                  reason = thtrk_pkg::RSN_SYN_SEQ;
               end else begin
                  nxt.syn_seq = hdr.seq_num;
               end
            end else if (has_ack && !has_syn && bare) begin
               if (!syn_seen || (hdr.seq_num != syn_plus1)) begin
                  reason = thtrk_pkg::RSN_OUT_ACK_SEQ;
               end else if (!synack_seen || (hdr.ack_num != synack_plus1)) begin
                  reason = thtrk_pkg::RSN_OUT_ACK_ACK;
               end else begin
                  // handshake complete: pass the ack and ask for the fake segment
                  nxt.fake_done   = 1'b1;
                  res.inject_fake = 1'b1;
                  res.fake_seq    = syn_plus1 -
                                    {{(thtrk_pkg::SEQ_W-thtrk_pkg::FAKE_W){1'b0}}, cfg.fake_len};
                  res.fake_flags  = hdr.tcp_flags | thtrk_pkg::F_PSH;
               end
            end else begin
               reason = thtrk_pkg::RSN_OUT_OTHER;
            end
         end

         if (reason != thtrk_pkg::RSN_NONE) begin
            nxt.monitoring    = 1'b0;
            nxt.final_outcome = thtrk_pkg::OUTCOME_CLOSED;
            res.forward       = 1'b1;
         end
      end

      res.reason  = reason;
      res.outcome = nxt.final_outcome;
   end

endmodule

>>> sv/thtrk_csr.sv
// configuration registers of the tracker, plain write port without read-back
// depends on thtrk_pkg
module thtrk_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [thtrk_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [thtrk_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output thtrk_pkg::conn_cfg_type          cfg,
   output logic                             track_enable,
   output logic                             restart
);

   thtrk_pkg::conn_cfg_type cfg_ff, cfg_in;
   logic                    enable_ff, enable_in;
   logic                    restart_in;

   always_comb begin
      cfg_in     = cfg_ff;
      enable_in  = enable_ff;
      restart_in = 1'b0;
      if (csr_we) begin
         unique case (thtrk_pkg::csr_idx_type'(csr_addr))
            thtrk_pkg::CSR_LOCAL_IP:     cfg_in.local_ip    = csr_wdata[thtrk_pkg::IP_W-1:0];
            thtrk_pkg::CSR_LOCAL_PORT:   cfg_in.local_port  = csr_wdata[thtrk_pkg::PORT_W-1:0];
            thtrk_pkg::CSR_REMOTE_IP:    cfg_in.remote_ip   = csr_wdata[thtrk_pkg::IP_W-1:0];
            thtrk_pkg::CSR_REMOTE_PORT:  cfg_in.remote_port = csr_wdata[thtrk_pkg::PORT_W-1:0];
            thtrk_pkg::CSR_FAKE_LEN:     cfg_in.fake_len    = csr_wdata[thtrk_pkg::FAKE_W-1:0];
            thtrk_pkg::CSR_TRACK_ENABLE: begin
               enable_in  = csr_wdata[0];
               restart_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         enable_ff <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         enable_ff <= enable_in;
      end
   end

   assign cfg          = cfg_ff;
   // new enable value goes straight to the tracker state on the write edge
   assign track_enable = enable_in;
   assign restart      = restart_in;

endmodule

>>> sv/tcp_handshake_tracker.sv
// tcp handshake tracker top level: input register, decision logic, result register
// depends on thtrk_pkg, thtrk_csr and thtrk_decide
// path: the req beat is held in the input register, decided, then held in the result
//    register, from which the rsp beat is offered
// throughput: one beat per cycle unless rsp_tready stalls; the handshake state is updated on
//    the same edge that loads the result register, so the next beat sees it straight away
// reset: synchronous, active high; clears the valid bits of both pipeline stages and the
//    configuration to 0, and the tracker to not monitoring with no sequence numbers seen
module tcp_handshake_tracker (
   input  logic                               clock,
   input  logic                               reset,
   // request side
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // outbound, packet_len, ip_version, protocol, src_ip, dst_ip, src_port,
   // dst_port, tcp_flags, seq_num, ack_num, payload_len, zero pad
   input  logic [thtrk_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response side
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // forward, inject_fake, fake_seq, fake_flags, matched, outcome, reason, zero pad
   output logic [thtrk_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write port
   input  logic                               csr_we,
   input  logic [thtrk_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [thtrk_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   thtrk_pkg::conn_cfg_type    cfg;
   logic                       track_enable;
   logic                       restart;

   // input register
   logic                       in_valid_ff, in_valid_in;
   thtrk_pkg::hdr_type         hdr_ff, hdr_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   thtrk_pkg::result_type      res_ff, res_in;

   // tracker state
   thtrk_pkg::track_state_type state_ff, state_in;
   thtrk_pkg::track_state_type state_nxt;
   thtrk_pkg::result_type      res_comb;

   logic                       advance;
   logic                       req_take;

   thtrk_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .track_enable (track_enable),
      .restart      (restart)
   );

   thtrk_decide u_decide (
      .hdr (hdr_ff),
      .cfg (cfg),
      .cur (state_ff),
      .res (res_comb),
      .nxt (state_nxt)
   );

   // the held beat moves on whenever the result register is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      hdr_in      = hdr_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         hdr_in      = thtrk_pkg::unpack_req(req_tdata);
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         res_in       = res_comb;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // the user must write track_enable only while idle, so it never meets an advancing beat; not enforced here
   always_comb begin
      state_in = state_ff;
      if (restart) begin
         state_in.syn_seq       = thtrk_pkg::NOT_SEEN;
         state_in.synack_seq    = thtrk_pkg::NOT_SEEN;
         state_in.monitoring    = track_enable;
         state_in.fake_done     = 1'b0;
         state_in.final_outcome = thtrk_pkg::OUTCOME_NONE;
      end else if (advance) begin
         state_in = state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         state_ff.syn_seq       <= thtrk_pkg::NOT_SEEN;
         state_ff.synack_seq    <= thtrk_pkg::NOT_SEEN;
         state_ff.monitoring    <= 1'b0;
         state_ff.fake_done     <= 1'b0;
         state_ff.final_outcome <= thtrk_pkg::OUTCOME_NONE;
      end else begin
         in_valid_ff            <= in_valid_in;
         out_valid_ff           <= out_valid_in;
         state_ff               <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      res_ff <= res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = thtrk_pkg::pack_rsp(res_ff);

endmodule

>>> sv/thtrk_checker.sv
// port-level checks for the tcp handshake tracker, bound to the top level
// depends on thtrk_pkg and tcp_handshake_tracker
module thtrk_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [thtrk_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   thtrk_pkg::result_type rsp;
   assign rsp = thtrk_pkg::result_type'(rsp_tdata[$bits(thtrk_pkg::result_type)-1:0]);

   // nothing comes out of the pipe in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   // a fake request only ever rides on a forwarded, fault-free, matched packet
   a_inject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.inject_fake |-> rsp.forward && rsp.matched &&
         (rsp.reason == thtrk_pkg::RSN_NONE) && (rsp.outcome == thtrk_pkg::OUTCOME_NONE))
      else $error("fake request on a bad beat");

   // dropping happens only on success of the tracked connection
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.forward |-> rsp.matched &&
         (rsp.outcome == thtrk_pkg::OUTCOME_SUCCESS) && (rsp.reason == thtrk_pkg::RSN_NONE))
      else $error("packet dropped without success");

   a_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.reason != thtrk_pkg::RSN_NONE) |-> rsp.forward && rsp.matched &&
         (rsp.outcome == thtrk_pkg::OUTCOME_CLOSED) && !rsp.inject_fake)
      else $error("fault reason without close");

endmodule

bind tcp_handshake_tracker thtrk_checker u_thtrk_checker (.*);

>>> tb/sv/thtrk_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the tcp handshake tracker bench: predicts the verdict of every
// header beat and checks the result beats against those verdicts in order
// depends on thtrk_pkg for the header, verdict and register types
package thtrk_tb_pkg;
   import thtrk_pkg::*;

   class handshake_scoreboard;
      conn_cfg_type    conn;
      logic            track_en;
      track_state_type hs;
      result_type      verdict_q[$];
      int unsigned     errors;

      function new();
         conn     = '0;
         track_en = 1'b0;
         errors   = 0;
         restart();
      endfunction

      function void restart();
         hs.syn_seq       = NOT_SEEN;
         hs.synack_seq    = NOT_SEEN;
         hs.monitoring    = track_en;
         hs.fake_done     = 1'b0;
         hs.final_outcome = OUTCOME_NONE;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] value);
         case (idx)
            CSR_LOCAL_IP:     conn.local_ip    = value;
            CSR_LOCAL_PORT:   conn.local_port  = value[PORT_W-1:0];
            CSR_REMOTE_IP:    conn.remote_ip   = value;
            CSR_REMOTE_PORT:  conn.remote_port = value[PORT_W-1:0];
            CSR_FAKE_LEN:     conn.fake_len    = value[FAKE_W-1:0];
            CSR_TRACK_ENABLE: begin
               track_en = value[0];
               restart();
            end
            default: ;
         endcase
      endfunction

      // works out the verdict of one accepted header and moves the tracker on
      function void note_header(hdr_type h);
         result_type       v;
         reason_type       why;
         logic             bare, has_syn, has_ack;
         logic [SEQ_W-1:0] syn_next, synack_next;
         v           = '0;
         v.forward   = 1'b1;
         why         = RSN_NONE;
         bare        = (h.tcp_flags & (F_RST | F_FIN)) == '0 && h.payload_len == '0;
         has_syn     = (h.tcp_flags & F_SYN) != '0;
         has_ack     = (h.tcp_flags & F_ACK) != '0;
         syn_next    = hs.syn_seq + 32'd1;
         synack_next = hs.synack_seq + 32'd1;
         if (h.packet_len >= MIN_LEN && h.ip_version == IPV4 && h.protocol == PROTO_TCP) begin
            if (h.outbound) begin
               v.matched = h.src_ip == conn.local_ip && h.src_port == conn.local_port &&
                           h.dst_ip == conn.remote_ip && h.dst_port == conn.remote_port;
            end else begin
               v.matched = h.dst_ip == conn.local_ip && h.dst_port == conn.local_port &&
                           h.src_ip == conn.remote_ip && h.src_port == conn.remote_port;
            end
         end
         if (v.matched && hs.monitoring) begin
            if (!h.outbound) begin
               if (has_syn && has_ack && bare) begin
                  if (hs.syn_seq == NOT_SEEN) why = RSN_SYNACK_NO_SYN;
                  else if (hs.synack_seq != NOT_SEEN && hs.synack_seq != h.seq_num)
                     why = RSN_SYNACK_SEQ;
                  else if (h.ack_num != syn_next) why = RSN_SYNACK_ACK;
                  else hs.synack_seq = h.seq_num;
               end else if (has_ack && !has_syn && bare && hs.fake_done) begin
                  if (hs.synack_seq == NOT_SEEN || h.seq_num != synack_next)
                     why = RSN_IN_ACK_SEQ;
                  else if (h.ack_num != syn_next) why = RSN_IN_ACK_ACK;
                  else begin
                     hs.monitoring    = 1'b0;
                     hs.final_outcome = OUTCOME_SUCCESS;
                     v.forward        = 1'b0;
                  end
               end else begin
                  why = RSN_IN_OTHER;
               end
            end else begin
               if (hs.fake_done) begin
                  why = RSN_AFTER_FAKE;
               end else if (has_syn && !has_ack && bare) begin
                  if (h.ack_num != '0) why = RSN_SYN_ACK_NONZERO;
                  else if (hs.syn_seq != NOT_SEEN && hs.syn_seq != h.seq_num) why = RSN_SYN_SEQ;
                  else hs.syn_seq = h.seq_num;
               end else if (has_ack && !has_syn && bare) begin
                  if (hs.syn_seq == NOT_SEEN || h.seq_num != syn_next) why = RSN_OUT_ACK_SEQ;
                  else if (hs.synack_seq == NOT_SEEN || h.ack_num != synack_next)
                     why = RSN_OUT_ACK_ACK;
                  else begin
                     hs.fake_done  = 1'b1;
                     v.inject_fake = 1'b1;
                     v.fake_seq    = syn_next - 32'(conn.fake_len);
                     v.fake_flags  = h.tcp_flags | F_PSH;
                  end
               end else begin
                  why = RSN_OUT_OTHER;
               end
            end
            if (why != RSN_NONE) begin
               hs.monitoring    = 1'b0;
               hs.final_outcome = OUTCOME_CLOSED;
               v.forward        = 1'b1;
            end
         end
         v.outcome = hs.final_outcome;
         v.reason  = why;
         verdict_q.push_back(v);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (verdict_q.size() == 0) begin
            $error("result beat arrived with no verdict outstanding");
            errors++;
            return;
         end
         want = verdict_q.pop_front();
         compare("forward", want.forward, got.forward);
         compare("inject_fake", want.inject_fake, got.inject_fake);
         compare("fake_seq", want.fake_seq, got.fake_seq);
         compare("fake_flags", want.fake_flags, got.fake_flags);
         compare("matched", want.matched, got.matched);
         compare("outcome", want.outcome, got.outcome);
         compare("reason", want.reason, got.reason);
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

endpackage

>>> tb/sv/tcp_handshake_tracker_test.sv
`timescale 1ns / 1ps
// top of the tcp handshake tracker bench: clock, reset, beat drivers, handshake
// sessions with random content and the end of run verdict
// depends on thtrk_pkg, thtrk_tb_pkg and the tcp_handshake_tracker rtl
module tcp_handshake_tracker_test;
   import thtrk_pkg::*;
   import thtrk_tb_pkg::*;

   localparam int TOTAL_BEATS = 520;     // directed part plus about 500 random beats
   localparam int CYCLE_LIMIT = 300000;  // far above the slowest legal run

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DAT_W-1:0]  csr_wdata;

   handshake_scoreboard score = new();

   int beats_sent    = 0;
   int hold_request  = 0;   // receiver hold-off length, picked up by the sink process
   bit tx_calm       = 1'b0;
   bit rx_calm       = 1'b0;
   int cycle_count   = 0;

   tcp_handshake_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends here
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // mostly back to back, now and then a short gap, rarely a long one
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sequence numbers lean on the wrap points and the all ones value
   function automatic logic [SEQ_W-1:0] pick_seq();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'hFFFF_FFFE;
         2:       return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // addresses and ports for the register writes, upper bits of ports left random
   function automatic logic [CSR_DAT_W-1:0] pick_addr();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // flag bits that do not change the handshake decision: psh, urg, ece, cwr
   function automatic logic [FLAG_W-1:0] spare_flags();
      return 8'($urandom) & 8'hE8;
   endfunction

   // a header of the configured connection in the given direction, with no payload
   function automatic hdr_type conn_header(input logic outb, input logic [FLAG_W-1:0] flags,
                                           input logic [SEQ_W-1:0] seq, ack);
      hdr_type h;
      int      pick;
      pick         = $urandom_range(0, 9);
      h            = '0;
      h.outbound   = outb;
      h.packet_len = pick == 0 ? MIN_LEN : pick == 1 ? 16'hFFFF : 16'($urandom_range(20, 65535));
      h.ip_version = IPV4;
      h.protocol   = PROTO_TCP;
      if (outb) begin
         h.src_ip   = score.conn.local_ip;
         h.src_port = score.conn.local_port;
         h.dst_ip   = score.conn.remote_ip;
         h.dst_port = score.conn.remote_port;
      end else begin
         h.src_ip   = score.conn.remote_ip;
         h.src_port = score.conn.remote_port;
         h.dst_ip   = score.conn.local_ip;
         h.dst_port = score.conn.local_port;
      end
      h.tcp_flags = flags;
      h.seq_num   = seq;
      h.ack_num   = ack;
      return h;
   endfunction

   // traffic that the tracker must let through untouched: near misses and junk
   function automatic hdr_type stray_header();
      hdr_type        h;
      logic [223:0]   raw;
      h = conn_header(1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom);
      case ($urandom_range(0, 6))
         0: h.packet_len = 16'($urandom_range(0, 19));
         1: h.ip_version = 4'($urandom_range(5, 19));    // anything but 4
         2: h.protocol   = 8'($urandom_range(7, 260));   // anything but 6
         3: h.src_ip     = h.src_ip ^ $urandom_range(1, 32'hFFFF_FFFF);
         4: h.dst_ip     = h.dst_ip ^ $urandom_range(1, 32'hFFFF_FFFF);
         5: begin
            if ($urandom_range(0, 1)) h.src_port = h.src_port ^ 16'($urandom_range(1, 65535));
            else h.dst_port = h.dst_port ^ 16'($urandom_range(1, 65535));
         end
         default: begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            h   = hdr_type'(raw[$bits(hdr_type)-1:0]);
         end
      endcase
      return h;
   endfunction

   // one header beat; valid stays high from one beat to the next when there is no gap
   task automatic send_beat(input hdr_type h);
      int gap;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - $bits(hdr_type)){1'b0}}, h};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      score.note_header(h);
      beats_sent++;
   endtask

   // a connection beat, now and then spoilt, now and then after a stray beat
   task automatic send_conn(input logic outb, input logic [FLAG_W-1:0] flags,
                            input logic [SEQ_W-1:0] seq, ack,
                            input int break_pct, input int stray_pct);
      hdr_type h;
      if ($urandom_range(0, 99) < stray_pct) send_beat(stray_header());
      h = conn_header(outb, flags, seq, ack);
      if ($urandom_range(0, 99) < break_pct) begin
         case ($urandom_range(0, 4))
            0: h.seq_num     = h.seq_num ^ $urandom_range(1, 32'hFFFF_FFFF);
            1: h.ack_num     = h.ack_num ^ $urandom_range(1, 32'hFFFF_FFFF);
            2: h.tcp_flags   = 8'($urandom);
            3: h.payload_len = 16'($urandom_range(1, 65535));
            default: h.tcp_flags = h.tcp_flags | ($urandom_range(0, 1) ? F_RST : F_FIN);
         endcase
      end
      send_beat(h);
   endtask

   // one register write; the write port is quiet again when the task returns
   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      score.write_reg(idx, value);
      @(posedge clock);
   endtask

   // sender stops until every verdict is back; each beat gives exactly one result,
   // so the two stage pipe is empty once no verdict is pending
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (score.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // a three-way handshake with its closing ack; steps may go missing, repeat or break
   task automatic run_session(input int break_pct);
      logic [SEQ_W-1:0] isn, risn;
      int               tail;
      isn  = pick_seq();
      risn = pick_seq();
      tail = $urandom_range(0, 3);
      if ($urandom_range(0, 99) >= 4)
         send_conn(1'b1, F_SYN | spare_flags(), isn, 32'h0, break_pct, 20);
      if ($urandom_range(0, 99) < 12)   // retransmitted syn
         send_conn(1'b1, F_SYN | spare_flags(), isn, 32'h0, break_pct, 20);
      if ($urandom_range(0, 99) >= 4)
         send_conn(1'b0, F_SYN | F_ACK | spare_flags(), risn, isn + 32'd1, break_pct, 20);
      if ($urandom_range(0, 99) < 12)   // repeated syn-ack
         send_conn(1'b0, F_SYN | F_ACK | spare_flags(), risn, isn + 32'd1, break_pct, 20);
      if ($urandom_range(0, 99) >= 4)
         send_conn(1'b1, F_ACK | spare_flags(), isn + 32'd1, risn + 32'd1, break_pct, 20);
      send_conn(1'b0, F_ACK | spare_flags(), risn + 32'd1, isn + 32'd1, break_pct, 20);
      // whatever follows on the connection once the tracker has settled
      repeat (tail)
         send_conn(1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom, 0, 20);
   endtask

   // result sink: checks every beat and plays the receiver's stalls
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            score.check_result(result_type'(rsp_tdata[$bits(result_type)-1:0]));
         if (hold_request > 0) begin
            // long hold-off so the pipe fills and req_tready drops
            stall_left   = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(rx_calm);
         end
      end
   end

   initial begin : stimulus
      hdr_type h;
      int      session_no;
      int      break_pct;
      logic    en;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_LOCAL_IP;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // every register once, tracking still off; the local port write carries junk in the upper half
      write_csr(CSR_LOCAL_IP, 32'h0);
      write_csr(CSR_LOCAL_PORT, 32'hFFFF_0000);
      write_csr(CSR_REMOTE_IP, 32'hFFFF_FFFF);
      write_csr(CSR_REMOTE_PORT, 32'h0000_FFFF);
      write_csr(CSR_FAKE_LEN, 32'h0);
      write_csr(CSR_TRACK_ENABLE, 32'h0);
      // not monitoring: connection beat passes with matched set and no reason
      send_conn(1'b1, F_SYN, 32'h1234_5678, 32'h0, 0, 0);
      wait_quiet();
      write_csr(CSR_TRACK_ENABLE, 32'h1);
      // one byte short of the minimum length
      h = conn_header(1'b1, F_SYN, 32'h0, 32'h0);
      h.packet_len = 16'd19;
      send_beat(h);
      // syn at exactly the minimum length whose sequence is all ones: stays unseen
      h = conn_header(1'b1, F_SYN | F_PSH, 32'hFFFF_FFFF, 32'h0);
      h.packet_len = MIN_LEN;
      send_beat(h);
      // so the syn-ack finds no syn and the connection closes
      send_conn(1'b0, F_SYN | F_ACK, 32'h5555_0000, 32'h0, 0, 0);
      wait_quiet();
      // fake length beyond a full segment: written as all ones, wraps the sequence
      write_csr(CSR_FAKE_LEN, 32'hFFFF_FFFF);
      write_csr(CSR_TRACK_ENABLE, 32'hFFFF_FFFF);
      h = conn_header(1'b0, F_SYN | F_ACK, 32'h0, 32'h1);
      h.ip_version = 4'd6;
      send_beat(h);
      h = conn_header(1'b1, F_ACK, 32'h0, 32'h0);
      h.protocol = 8'd17;
      send_beat(h);
      send_beat('1);
      send_beat('0);
      // clean handshake across the sequence wrap, fake inject, then the closing ack
      send_conn(1'b1, F_SYN, 32'h0, 32'h0, 0, 0);
      send_conn(1'b0, F_SYN | F_ACK, 32'hFFFF_FFFE, 32'h1, 0, 0);
      send_conn(1'b1, F_ACK | F_PSH, 32'h1, 32'hFFFF_FFFF, 0, 0);
      send_conn(1'b0, F_ACK, 32'hFFFF_FFFF, 32'h1, 0, 0);
      // tracking over: a fin is just forwarded and the success outcome holds
      send_conn(1'b0, F_FIN | F_ACK, 32'h0, 32'h1, 0, 0);
      wait_quiet();
      write_csr(CSR_LOCAL_IP, 32'hFFFF_FFFF);
      write_csr(CSR_LOCAL_PORT, 32'hFFFF_FFFF);
      write_csr(CSR_REMOTE_IP, 32'h0);
      write_csr(CSR_REMOTE_PORT, 32'h0);
      write_csr(CSR_FAKE_LEN, 32'd1460);
      write_csr(CSR_TRACK_ENABLE, 32'h1);
      // syn carrying the largest payload is not bare: closes on the outbound side
      h = conn_header(1'b1, F_SYN, $urandom, 32'h0);
      h.payload_len = 16'hFFFF;
      send_beat(h);

      // ---- random sessions, one tracker restart each ----
      session_no = 0;
      while (beats_sent < TOTAL_BEATS) begin
         wait_quiet();
         tx_calm = (session_no % 7) == 3;
         rx_calm = tx_calm;
         if ($urandom_range(0, 2) == 0) begin
            write_csr(CSR_LOCAL_IP, pick_addr());
            write_csr(CSR_LOCAL_PORT, pick_addr());
            write_csr(CSR_REMOTE_IP, pick_addr());
            write_csr(CSR_REMOTE_PORT, pick_addr());
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
               0:       write_csr(CSR_FAKE_LEN, 32'h0);
               1:       write_csr(CSR_FAKE_LEN, 32'd1460);
               2:       write_csr(CSR_FAKE_LEN, $urandom);
               default: write_csr(CSR_FAKE_LEN, $urandom_range(0, 1460));
            endcase
         end
         en = $urandom_range(0, 9) != 0;
         write_csr(CSR_TRACK_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(en));
         case ($urandom_range(0, 3))
            0:       break_pct = 25;
            1:       break_pct = 8;
            default: break_pct = 0;
         endcase
         if (session_no == 5) begin
            // receiver holds off while the sender keeps offering beats
            tx_calm      = 1'b1;
            hold_request = 150;
            repeat (30) send_beat(stray_header());
            run_session(0);
         end else begin
            run_session(break_pct);
         end
         session_no++;
      end

      wait_quiet();
      repeat (5) @(posedge clock);
      if (score.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
